[sv/cdsb_pkg.sv]
// Package for the character display shadow buffer.
// Holds request/result payload types, opcodes, sequencer states and glyph codes.
// No dependencies.
package cdsb_pkg;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [7:0]  end_pos;
        logic [8:0]  level;
        logic [15:0] progress_step;
        logic [7:0]  glyph;
    } t_req;

    typedef struct packed {
        logic       kind;
        logic       status;
        logic [3:0] out_row;
        logic [5:0] out_col;
        logic [7:0] out_glyph;
        logic       last;
    } t_rsp;

    localparam logic [2:0] OP_WRITE    = 3'd0;
    localparam logic [2:0] OP_HBAR     = 3'd1;
    localparam logic [2:0] OP_VBAR     = 3'd2;
    localparam logic [2:0] OP_PROGRESS = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;
    localparam logic [2:0] OP_FLUSH    = 3'd5;

    localparam logic [7:0] GL_SPACE = 8'h20;
    localparam logic [7:0] GL_DOT   = 8'h2E;
    localparam logic [7:0] GL_ARROW = 8'h3E;
    localparam logic [7:0] GL_FULL  = 8'h02;
    localparam logic [7:0] GL_BLANK = 8'hFF;
    localparam logic [7:0] GL_MARK  = 8'hFE;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_MOD,
        ST_MARK,
        ST_DRAW,
        ST_RDF,
        ST_CMPF,
        ST_HOLDF,
        ST_STATUS,
        ST_WAIT
    } t_state;

    // Glyph for bar cell i given fill v (units of 1/256 cell).
    function automatic logic [7:0] bar_glyph(input logic [14:0] v, input logic [6:0] i,
                                             input logic vert);
        logic [14:0] lo;
        logic [14:0] hi;
        logic [7:0]  f;
        logic [10:0] f5;
        begin
            lo = {i, 8'd0};
            hi = lo + 15'd256;
            f  = v[7:0];
            f5 = {3'd0, f} + {1'b0, f, 2'd0};
            if (v >= hi) begin
                bar_glyph = GL_FULL;
            end else if (v < lo) begin
                bar_glyph = GL_DOT;
            end else if (!vert) begin
                bar_glyph = f[7] ? 8'h01 : 8'h00;
            end else if (f5 < 11'd256) begin
                bar_glyph = 8'h03;
            end else if (!f[7]) begin
                bar_glyph = 8'h04;
            end else if (f5 < 11'd1024) begin
                bar_glyph = 8'h05;
            end else begin
                bar_glyph = 8'h06;
            end
        end
    endfunction

endpackage

[sv/char_display_shadow_buffer.sv]
// Character display shadow buffer: top level with sequencer and both stores.
// Depends on cdsb_pkg.
//
// Usage: requests arrive on i_req_valid/o_req_ready with an i_req payload;
// results leave on o_rsp_valid/i_rsp_ready with an o_rsp payload. One request
// is handled at a time and o_req_ready is low while it is in work.
// Every request other than flush gives one status result. A flush of a row
// gives one result per changed cell, in column order, the final one flagged
// last, or a single ok status when nothing changed.
// Before the first result: a rejected request goes straight to its status;
// a cell write writes one cell; a bar writes len cells (hbar up to WIDTH,
// vbar up to HEIGHT cells); progress takes the modulo by reciprocal
// multiply (quotient estimate, subtract, correction), then one write per
// column; clear writes every cell of both stores; flush reads, compares
// and holds each cell of the row in turn. Drawing that touches row 0 also
// marks every cell of shown row 0. Each store has one write port and one
// read port. The next request is taken the cycle after the final result
// is accepted. After reset a clearing pass fills both stores before the
// first request is accepted. When the receiver stalls the result holds in
// the output register; a flush holds its scan while a changed cell waits
// behind an unaccepted result.
module char_display_shadow_buffer #(
    parameter int WIDTH  = 20,
    parameter int HEIGHT = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  cdsb_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output cdsb_pkg::t_rsp  o_rsp
);
    import cdsb_pkg::*;

    localparam int NCELLS = WIDTH * HEIGHT;
    localparam int AW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    // Reciprocal of WIDTH in Q16 for the progress modulo.
    localparam logic [16:0] MOD_RECIP = 17'(65536 / WIDTH);

    t_state r_state, n_state;
    t_req   r_req, n_req;
    logic [AW-1:0]  r_addr, n_addr;
    logic [6:0]     r_i, n_i;
    logic [6:0]     r_len, n_len;
    logic [15:0]    r_s, n_s;
    logic [15:0]    r_q, n_q;
    logic [14:0]    r_v, n_v;
    logic           r_err, n_err;
    logic           r_mark, n_mark;
    logic [1:0]     r_phase, n_phase;
    logic           r_hold_v, n_hold_v;
    logic [5:0]     r_hold_col, n_hold_col;
    logic [7:0]     r_hold_glyph, n_hold_glyph;
    t_rsp   r_rsp, n_rsp;
    logic   r_rsp_valid, n_rsp_valid;

    logic [7:0] r_pend [NCELLS];
    logic [7:0] r_shown [NCELLS];
    logic [7:0] r_pq, r_sq;

    logic          p_we, s_we;
    logic [AW-1:0] p_wa, s_wa, rd_a;
    logic [7:0]    p_wd, s_wd;

    always_ff @(posedge i_clk) begin
        if (p_we) r_pend[p_wa] <= p_wd;
        if (s_we) r_shown[s_wa] <= s_wd;
        r_pq <= r_pend[rd_a];
        r_sq <= r_shown[rd_a];
    end

    // Checks against the store bounds.
    logic [8:0] w9, h9;
    assign w9 = 9'(WIDTH);
    assign h9 = 9'(HEIGHT);

    logic        bad;
    logic [8:0]  hlen, vlen;
    logic [14:0] lvl;
    always_comb begin
        lvl  = (i_req.level > 9'd256) ? 15'd256 : 15'(i_req.level);
        hlen = {1'b0, i_req.end_pos} - {1'b0, i_req.col} + 9'd1;
        vlen = {1'b0, i_req.row} - {1'b0, i_req.end_pos} + 9'd1;
        case (i_req.opcode)
            OP_WRITE:    bad = ({1'b0, i_req.row} >= h9) || ({1'b0, i_req.col} >= w9);
            OP_HBAR:     bad = (i_req.col > i_req.end_pos) || ({1'b0, i_req.row} >= h9)
                               || ({1'b0, i_req.end_pos} >= w9);
            OP_VBAR:     bad = (i_req.row < i_req.end_pos) || ({1'b0, i_req.row} >= h9)
                               || ({1'b0, i_req.col} >= w9);
            OP_PROGRESS: bad = ({1'b0, i_req.row} >= h9);
            OP_CLEAR:    bad = 1'b0;
            OP_FLUSH:    bad = ({1'b0, i_req.row} >= h9);
            default:     bad = 1'b1;
        endcase
    end

    logic [AW-1:0] row_base;
    assign row_base = AW'(32'(r_req.row[3:0]) * WIDTH);

    logic [15:0] s4;
    assign s4 = r_s + 16'd4;

    // Quotient estimate and its product for the progress modulo.
    logic [32:0] mod_prod;
    logic [15:0] mod_qw;
    assign mod_prod = {17'd0, r_s} * {16'd0, MOD_RECIP};
    assign mod_qw   = 16'(32'(r_q) * WIDTH);

    // A changed cell can only be taken once the previous one has gone out.
    logic cell_diff, flush_go;
    assign cell_diff = (r_pq != r_sq);
    assign flush_go  = !(cell_diff && r_hold_v) || !r_rsp_valid || i_rsp_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (32'(r_addr) == NCELLS - 1)
                    n_state = (r_req.opcode == OP_CLEAR) ? ST_STATUS : ST_IDLE;
            end
            ST_IDLE: if (i_req_valid && !r_rsp_valid) begin
                if (bad) n_state = ST_STATUS;
                else if (i_req.opcode == OP_CLEAR) n_state = ST_INIT;
                else if (i_req.opcode == OP_FLUSH) n_state = ST_RDF;
                else if (i_req.opcode == OP_PROGRESS) n_state = ST_MOD;
                else n_state = ST_DRAW;
            end
            ST_MOD:    if (r_phase == 2'd2) n_state = ST_DRAW;
            ST_DRAW:   if (r_i + 7'd1 >= r_len) n_state = r_mark ? ST_MARK : ST_STATUS;
            ST_MARK:   if (32'(r_i) == WIDTH - 1) n_state = ST_STATUS;
            ST_RDF:    n_state = ST_CMPF;
            ST_CMPF:   n_state = ST_HOLDF;
            ST_HOLDF:  if (flush_go) begin
                n_state = (32'(r_i) == WIDTH - 1) ? ST_STATUS : ST_RDF;
            end
            ST_STATUS: if (!r_rsp_valid || i_rsp_ready) n_state = ST_WAIT;
            ST_WAIT:   if (!r_rsp_valid || i_rsp_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        n_req = r_req; n_addr = r_addr; n_i = r_i; n_len = r_len; n_s = r_s; n_v = r_v;
        n_q = r_q; n_err = r_err; n_mark = r_mark; n_phase = r_phase;
        n_hold_v = r_hold_v; n_hold_col = r_hold_col; n_hold_glyph = r_hold_glyph;
        n_rsp = r_rsp; n_rsp_valid = r_rsp_valid;
        p_we = 1'b0; s_we = 1'b0; p_wa = r_addr; s_wa = r_addr;
        p_wd = GL_SPACE; s_wd = GL_BLANK; rd_a = row_base + AW'(r_i);
        o_req_ready = 1'b0;
        if (r_rsp_valid && i_rsp_ready) n_rsp_valid = 1'b0;
        case (r_state)
            ST_INIT: begin
                p_we = 1'b1; s_we = 1'b1;
                n_addr = r_addr + AW'(1);
            end
            ST_IDLE: begin
                o_req_ready = !r_rsp_valid;
                n_req = i_req; n_i = '0; n_err = bad; n_addr = '0; n_phase = 2'd0;
                n_hold_v = 1'b0;
                n_s = i_req.progress_step;
                if (i_req.opcode == OP_HBAR) begin
                    n_len = 7'(hlen); n_v = lvl * 15'(hlen);
                end else if (i_req.opcode == OP_VBAR) begin
                    n_len = 7'(vlen); n_v = lvl * 15'(vlen);
                end else if (i_req.opcode == OP_PROGRESS) begin
                    n_len = 7'(WIDTH);
                end else begin
                    n_len = 7'd1;
                end
                n_mark = (i_req.opcode == OP_VBAR) ? (i_req.end_pos == 8'd0)
                                                   : (i_req.row == 8'd0);
            end
            ST_MOD: begin
                n_phase = r_phase + 2'd1;
                case (r_phase)
                    2'd0:    n_q = mod_prod[31:16];
                    2'd1:    n_s = r_s - mod_qw;
                    default: if (r_s >= 16'(WIDTH)) n_s = r_s - 16'(WIDTH);
                endcase
            end
            ST_DRAW: begin
                p_we = 1'b1;
                n_i = r_i + 7'd1;
                case (r_req.opcode)
                    OP_WRITE: begin
                        p_wa = row_base + AW'(r_req.col);
                        p_wd = r_req.glyph;
                    end
                    OP_HBAR: begin
                        p_wa = row_base + AW'(r_req.col) + AW'(r_i);
                        p_wd = bar_glyph(r_v, r_i, 1'b0);
                    end
                    OP_VBAR: begin
                        p_wa = AW'(32'(r_req.row[3:0] - r_i[3:0]) * WIDTH) + AW'(r_req.col);
                        p_wd = bar_glyph(r_v, r_i, 1'b1);
                    end
                    default: begin
                        p_wa = row_base + AW'(r_i);
                        if ({9'd0, r_i} >= r_s && {9'd0, r_i} < s4) p_wd = GL_ARROW;
                        else if (s4 > 16'(WIDTH) && {9'd0, r_i} < s4 - 16'(WIDTH))
                            p_wd = GL_ARROW;
                        else p_wd = GL_SPACE;
                    end
                endcase
                if (r_i + 7'd1 >= r_len) n_i = '0;
            end
            ST_MARK: begin
                s_we = 1'b1; s_wa = AW'(r_i); s_wd = GL_MARK;
                n_i = r_i + 7'd1;
            end
            ST_HOLDF: begin
                // Hold each changed cell until the next one is found, so that
                // last lands on the true final one.
                if (flush_go && cell_diff) begin
                    s_we = 1'b1; s_wa = row_base + AW'(r_i); s_wd = r_pq;
                    n_hold_v = 1'b1; n_hold_col = 6'(r_i); n_hold_glyph = r_pq;
                    if (r_hold_v) begin
                        n_rsp_valid = 1'b1;
                        n_rsp = '{kind: 1'b1, status: 1'b0, out_row: r_req.row[3:0],
                                  out_col: r_hold_col, out_glyph: r_hold_glyph,
                                  last: 1'b0};
                    end
                end
                if (flush_go) n_i = r_i + 7'd1;
            end
            ST_STATUS: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp_valid = 1'b1;
                    if (r_hold_v)
                        n_rsp = '{kind: 1'b1, status: 1'b0, out_row: r_req.row[3:0],
                                  out_col: r_hold_col, out_glyph: r_hold_glyph,
                                  last: 1'b1};
                    else
                        n_rsp = '{kind: 1'b0, status: r_err, out_row: 4'd0, out_col: 6'd0,
                                  out_glyph: 8'd0, last: 1'b1};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_addr <= '0;
            r_rsp_valid <= 1'b0;
            r_req <= '0;
            r_hold_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr <= n_addr;
            r_rsp_valid <= n_rsp_valid;
            r_req <= n_req;
            r_hold_v <= n_hold_v;
        end
        r_i <= n_i; r_len <= n_len; r_s <= n_s; r_v <= n_v; r_q <= n_q;
        r_err <= n_err; r_mark <= n_mark; r_phase <= n_phase;
        r_hold_col <= n_hold_col; r_hold_glyph <= n_hold_glyph;
        r_rsp <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp = r_rsp;
endmodule
